// ----- rtl/gik_pkg.sv -----
// ----------------------------------------------------------------------------
// gik_pkg
// Shared widths, status codes and item types for the key grouping unit.
// ----------------------------------------------------------------------------
package gik_pkg;

	localparam int IDX_W  = 16;   // point index width
	localparam int KEY_W  = 6;    // subgrid key width
	localparam int CNT_W  = 7;    // counts up to 64
	localparam int ST_W   = 2;    // status width
	localparam int KEYS   = 64;   // full key space
	localparam int MASK_W = 64;   // staged mask width

	localparam int MAX_POINTS_DEF   = 64;
	localparam int NUM_SUBGRIDS_DEF = 64;

	// status codes
	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_UNSTAGED = 2'd1;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

	// one input word as queued between front and back
	typedef struct packed {
		logic [IDX_W-1:0] point_index;
		logic [KEY_W-1:0] subgrid_key;
		logic             last_point;
	} item_t;

	// back end handshake towards the front queue
	typedef struct packed {
		logic pop;
		logic run_done;
	} back_ctl_t;

endpackage

// ----- rtl/gik_ram.sv -----
// ----------------------------------------------------------------------------
// gik_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module gik_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/gik_front.sv -----
// ----------------------------------------------------------------------------
// gik_front
// Accepts input words into a two-entry queue and holds off new words
// while a flagged set is being grouped and emitted.
// ----------------------------------------------------------------------------
module gik_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  gik_pkg::item_t    item_in,
	output logic              busy,
	output logic              q_valid,
	output gik_pkg::item_t    q_item,
	input  gik_pkg::back_ctl_t ctl
);
	import gik_pkg::*;

	item_t      ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       run_q;
	logic       push;

	assign busy    = (cnt_q == 2'd2) || run_q;
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = ent_q[rptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= item_in;
		end
	end

	// queue pointers and run flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
			run_q  <= 1'b0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (ctl.pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(ctl.pop);
			if (push && item_in.last_point) begin
				run_q <= 1'b1;
			end else if (ctl.run_done) begin
				run_q <= 1'b0;
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("front queue count out of range");

endmodule

// ----- rtl/gik_back.sv -----
// ----------------------------------------------------------------------------
// gik_back
// Builds one linked list of points per key while loading, then walks the
// keys in ascending order and emits each list with group counts, ending the run after an unstaged key's list.
// ----------------------------------------------------------------------------
module gik_back #(
	parameter int MAX_POINTS   = gik_pkg::MAX_POINTS_DEF,
	parameter int NUM_SUBGRIDS = gik_pkg::NUM_SUBGRIDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  gik_pkg::item_t               q_item,
	output gik_pkg::back_ctl_t           ctl,
	input  logic [gik_pkg::MASK_W-1:0]   staged_mask,
	output logic                         result_valid,
	output logic [gik_pkg::IDX_W-1:0]    sorted_index,
	output logic [gik_pkg::KEY_W-1:0]    group_key,
	output logic                         group_end,
	output logic [gik_pkg::CNT_W-1:0]    group_count,
	output logic [gik_pkg::CNT_W-1:0]    group_total,
	output logic [gik_pkg::ST_W-1:0]     status,
	output logic                         run_last
);
	import gik_pkg::*;

	localparam int PW   = $clog2(MAX_POINTS);
	localparam int KTW  = 2 * PW + CNT_W;
	localparam int KAW  = $clog2(KEYS);

	localparam logic [2:0] S_LOAD = 3'd0;
	localparam logic [2:0] S_LWR  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_HEAD = 3'd3;
	localparam logic [2:0] S_WALK = 3'd4;

	logic [2:0]       state_q;
	item_t            item_q;
	logic [KEYS-1:0]  present_q;
	logic [CNT_W-1:0] fill_q;
	logic             ovf_q;
	logic [CNT_W-1:0] groups_q;
	logic [CNT_W-1:0] done_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] remain_q;
	logic [CNT_W-1:0] gcnt_q;

	logic             res_valid_q;
	logic [IDX_W-1:0] res_idx_q;
	logic [KEY_W-1:0] res_key_q;
	logic             res_end_q;
	logic [CNT_W-1:0] res_cnt_q;
	logic [CNT_W-1:0] res_tot_q;
	logic [ST_W-1:0]  res_st_q;
	logic             res_last_q;

	// key table: head, tail, count per key
	logic             kt_we;
	logic [KAW-1:0]   kt_raddr;
	logic [KTW-1:0]   kt_wdata;
	logic [KTW-1:0]   kt_rdata;
	logic [PW-1:0]    kt_head;
	logic [PW-1:0]    kt_tail;
	logic [CNT_W-1:0] kt_cnt;

	logic             pt_we;
	logic             nx_we;
	logic [PW-1:0]    fill_ptr;
	logic [PW-1:0]    rd_ptr;
	logic [IDX_W-1:0] pt_rdata;
	logic [PW-1:0]    nx_rdata;

	logic             room;
	logic             hit;
	logic             staged;
	logic             finish;

	assign kt_head  = kt_rdata[KTW-1 -: PW];
	assign kt_tail  = kt_rdata[CNT_W +: PW];
	assign kt_cnt   = kt_rdata[CNT_W-1:0];
	assign fill_ptr = fill_q[PW-1:0];
	assign room     = (fill_q != CNT_W'(MAX_POINTS));
	assign hit      = present_q[item_q.subgrid_key];
	assign staged   = (int'(key_q) < NUM_SUBGRIDS) && staged_mask[key_q];

	// memory address and write control
	always_comb begin
		kt_raddr = (state_q == S_LOAD) ? q_item.subgrid_key : key_q;
		rd_ptr   = (state_q == S_HEAD) ? kt_head : nx_rdata;
		kt_we    = (state_q == S_LWR) && room;
		pt_we    = kt_we;
		nx_we    = kt_we && hit;
		if (hit) begin
			kt_wdata = {kt_head, fill_ptr, kt_cnt + CNT_W'(1)};
		end else begin
			kt_wdata = {fill_ptr, fill_ptr, CNT_W'(1)};
		end
	end

	gik_ram #(.WIDTH(KTW), .DEPTH(KEYS)) u_keytab (
		.clk(clk), .we(kt_we), .waddr(item_q.subgrid_key), .wdata(kt_wdata),
		.raddr(kt_raddr), .rdata(kt_rdata)
	);

	gik_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_points (
		.clk(clk), .we(pt_we), .waddr(fill_ptr), .wdata(item_q.point_index),
		.raddr(rd_ptr), .rdata(pt_rdata)
	);

	gik_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_next (
		.clk(clk), .we(nx_we), .waddr(kt_tail), .wdata(fill_ptr),
		.raddr(rd_ptr), .rdata(nx_rdata)
	);

	// end of run: last point of an unstaged group, or of the final group
	assign finish = (state_q == S_WALK) && (remain_q == CNT_W'(1)) &&
		(!staged || (done_q + CNT_W'(1) == groups_q));

	assign ctl.pop      = (state_q == S_LOAD) && q_valid;
	assign ctl.run_done = finish;

	// held item
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			item_q <= q_item;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			present_q <= '0;
			fill_q    <= '0;
			ovf_q     <= 1'b0;
			groups_q  <= '0;
			done_q    <= '0;
			key_q     <= '0;
			remain_q  <= '0;
			gcnt_q    <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (q_valid) begin
						state_q <= S_LWR;
					end
				end
				S_LWR: begin
					if (room) begin
						fill_q <= fill_q + CNT_W'(1);
						if (!hit) begin
							present_q[item_q.subgrid_key] <= 1'b1;
							groups_q <= groups_q + CNT_W'(1);
						end
					end else begin
						ovf_q <= 1'b1;
					end
					if (item_q.last_point) begin
						state_q <= S_SCAN;
						key_q   <= '0;
						done_q  <= '0;
					end else begin
						state_q <= S_LOAD;
					end
				end
				S_SCAN: begin
					if (present_q[key_q]) begin
						state_q <= S_HEAD;
					end else begin
						key_q <= key_q + KEY_W'(1);
					end
				end
				S_HEAD: begin
					remain_q <= kt_cnt;
					gcnt_q   <= kt_cnt;
					state_q  <= S_WALK;
				end
				S_WALK: begin
					if (finish) begin
						state_q   <= S_LOAD;
						present_q <= '0;
						fill_q    <= '0;
						ovf_q     <= 1'b0;
						groups_q  <= '0;
					end else if (remain_q == CNT_W'(1)) begin
						done_q  <= done_q + CNT_W'(1);
						key_q   <= key_q + KEY_W'(1);
						state_q <= S_SCAN;
					end else begin
						remain_q <= remain_q - CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (state_q == S_WALK);
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (state_q == S_WALK) begin
			res_idx_q  <= pt_rdata;
			res_key_q  <= key_q;
			res_end_q  <= (remain_q == CNT_W'(1));
			res_cnt_q  <= (remain_q == CNT_W'(1)) ? gcnt_q : '0;
			res_tot_q  <= '0;
			res_st_q   <= ST_OK;
			res_last_q <= finish;
			if (finish) begin
				if (!staged) begin
					res_st_q <= ST_UNSTAGED;
				end else begin
					res_tot_q <= groups_q;
					res_st_q  <= ovf_q ? ST_OVERFLOW : ST_OK;
				end
			end
		end
	end

	assign result_valid = res_valid_q;
	assign sorted_index = res_idx_q;
	assign group_key    = res_key_q;
	assign group_end    = res_end_q;
	assign group_count  = res_cnt_q;
	assign group_total  = res_tot_q;
	assign status       = res_st_q;
	assign run_last     = res_last_q;

	a_clear_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_last_q) |-> (present_q == '0 && fill_q == '0))
		else $error("run state not cleared after final word");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_POINTS)) else $error("fill count beyond capacity");

	a_pop_only_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |=> (state_q == S_LWR)) else $error("pop outside load");

endmodule

// ----- rtl/group_indices_by_key_with_counts_unit.sv -----
// ----------------------------------------------------------------------------
// group_indices_by_key_with_counts_unit
// Groups loaded point indices by subgrid key, keeping arrival order within
// a key, and reports group counts, group total and staging status.
// ----------------------------------------------------------------------------
//  channel   handshake                      words
//  input     start / busy                   point_index, subgrid_key, last_point
//  result    result_valid                   sorted_index .. run_last
//  config    APB psel/penable/pwrite        staged_mask at byte address 0
//
//  The back end loads each point by a key table read, then a list update;
//  a two-entry queue takes words at 1 per cycle while busy is low.
//  Emission scans the keys (up to 64), reads the head of each present
//  group, then emits its points in list order. busy stays high from the
//  flagged word until the final result. Results cannot be stalled. Reset
//  clears all control state; point memories need no clearing.
// ----------------------------------------------------------------------------
module group_indices_by_key_with_counts_unit #(
	parameter int MAX_POINTS   = gik_pkg::MAX_POINTS_DEF,
	parameter int NUM_SUBGRIDS = gik_pkg::NUM_SUBGRIDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [gik_pkg::IDX_W-1:0]   point_index,
	input  logic [gik_pkg::KEY_W-1:0]   subgrid_key,
	input  logic                        last_point,
	output logic                        result_valid,
	output logic [gik_pkg::IDX_W-1:0]   sorted_index,
	output logic [gik_pkg::KEY_W-1:0]   group_key,
	output logic                        group_end,
	output logic [gik_pkg::CNT_W-1:0]   group_count,
	output logic [gik_pkg::CNT_W-1:0]   group_total,
	output logic [gik_pkg::ST_W-1:0]    status,
	output logic                        run_last,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready
);
	import gik_pkg::*;

	logic [MASK_W-1:0] mask_q;
	item_t             item_in;
	item_t             q_item;
	logic              q_valid;
	back_ctl_t         ctl;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (psel && penable && pwrite && paddr == 3'd0) begin
			mask_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? mask_q : '0;

	assign item_in = '{point_index: point_index, subgrid_key: subgrid_key,
		last_point: last_point};

	gik_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .item_in(item_in),
		.busy(busy), .q_valid(q_valid), .q_item(q_item), .ctl(ctl)
	);

	gik_back #(.MAX_POINTS(MAX_POINTS), .NUM_SUBGRIDS(NUM_SUBGRIDS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item),
		.ctl(ctl), .staged_mask(mask_q), .result_valid(result_valid),
		.sorted_index(sorted_index), .group_key(group_key),
		.group_end(group_end), .group_count(group_count),
		.group_total(group_total), .status(status), .run_last(run_last)
	);

endmodule
